// File: src/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// constants and types for the signed binary to decimal ascii unit
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int VALUE_BITS = 64;
  // decimal digits that cover any magnitude up to 2^VALUE_BITS - 1
  localparam int DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * DIGITS;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int DIG_W      = $clog2(DIGITS + 1);
  localparam int CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

endpackage

// File: src/signed_binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_unit
// converts one two's complement integer into its decimal ascii text
// ----------------------------------------------------------------------------
// One value is taken at a time and comes out as decimal text, most significant
// digit first, one character per output beat, with last set on the final
// digit. A negative value starts with '-'; zero gives a single '0'; leading
// zeros are never sent. The magnitude is turned into BCD by a bit-serial
// shift-and-add-3 loop, one input bit per cycle over all VALUE_BITS (64) bits.
// Leading zeros are then dropped, one per cycle, until the first nonzero
// digit or the last digit is reached, and the digits follow at one per cycle
// while the output is not stalled. A '-' goes out as its own beat before the
// digits. A new value is accepted only after the last character has been
// loaded into the output register.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_unit
  import sbda_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [63:0]       value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAR_W-1:0] character_o,
  output logic              last_o
);

  state_e                  state_q, state_d;
  logic [VALUE_BITS-1:0]   mag_q, mag_d;
  logic [BCD_W-1:0]        bcd_q, bcd_d;
  logic [BCD_W-1:0]        bcd_adj;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [DIG_W-1:0]        dig_q, dig_d;
  logic                    sign_q, sign_d;
  logic                    out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]       char_q, char_d;
  logic                    last_q, last_d;
  logic [VALUE_BITS-1:0]   raw;
  logic [3:0]              top;
  logic                    out_free;

  assign raw      = value_i[VALUE_BITS-1:0];
  assign top      = bcd_q[BCD_W-1 -: 4];
  assign out_free = !out_valid_q || !out_stall_i;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sign_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sign_q      <= sign_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    dig_q  <= dig_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    dig_d       = dig_q;
    sign_d      = sign_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sign_d  = raw[VALUE_BITS-1];
          mag_d   = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
          bcd_d   = '0;
          cnt_d   = CNT_W'(VALUE_BITS - 1);
          dig_d   = DIG_W'(DIGITS);
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d = {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
        mag_d = mag_q << 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top == 4'd0 && dig_q > DIG_W'(1)) begin
          bcd_d = bcd_q << 4;
          dig_d = dig_q - DIG_W'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (sign_q) begin
            char_d = CHAR_MINUS;
            last_d = 1'b0;
            sign_d = 1'b0;
          end else begin
            char_d = CHAR_ZERO + {2'b00, top};
            last_d = (dig_q == DIG_W'(1));
            bcd_d  = bcd_q << 4;
            dig_d  = dig_q - DIG_W'(1);
            if (dig_q == DIG_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_CONV)
    else $error("accepted beat did not start a conversion");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == CHAR_MINUS ||
                     (character_o >= CHAR_ZERO && character_o <= CHAR_NINE)))
    else $error("output character out of range");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && character_o == CHAR_MINUS |-> !last_o)
    else $error("minus sign flagged as last");

  a_sign_before_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && sign_q |-> dig_q != '0)
    else $error("sign pending with no digits left");

endmodule

// File: dv/tb_signed_binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// tb_signed_binary_to_decimal_ascii_unit
// self-checking bench for the signed binary to decimal ascii unit
// ----------------------------------------------------------------------------
// Values are fed from a queue by a clocked driver. Each value the block
// accepts is turned into its expected decimal text, one entry per character,
// by a predictor in the bench. A clocked monitor compares every output beat
// with the oldest expected character. A directed set covers zero, the
// extremes, the most negative value and the digit-count boundaries. The
// random part mixes full-width, narrow and near-power-of-ten values. The run
// goes through three idling patterns, holds the output back for a long
// stretch, and pauses the input until all text has drained.
// ----------------------------------------------------------------------------
module tb_signed_binary_to_decimal_ascii_unit;
  import sbda_pkg::*;

  localparam int MAX_CHARS   = 20;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_WAIT  = 200;
  localparam int RANDOM_ITEMS_PER_PHASE = 100;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_beat_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [63:0]       value_i     = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CHAR_W-1:0] character_o;
  logic              last_o;

  logic [63:0] pending_values[$];
  text_beat_t  expected_text[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int errors        = 0;
  int cycles        = 0;

  signed_binary_to_decimal_ascii_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decimal text of the low VALUE_BITS bits, read as two's complement
  task automatic predict_decimal_text(input logic [63:0] value);
    logic [63:0] mask;
    logic [63:0] raw;
    logic [63:0] magnitude;
    logic        negative;
    logic [3:0]  digits[MAX_CHARS];
    int          count;
    text_beat_t  beat;
    mask      = {64{1'b1}} >> (64 - VALUE_BITS);
    raw       = value & mask;
    negative  = raw[VALUE_BITS-1];
    magnitude = negative ? ((64'd0 - raw) & mask) : raw;
    count     = 0;
    do begin
      digits[count] = 4'(magnitude % 64'd10);
      magnitude     = magnitude / 64'd10;
      count++;
    end while (magnitude != 64'd0 && count < MAX_CHARS);
    if (negative) begin
      beat.character = CHAR_MINUS;
      beat.last      = 1'b0;
      expected_text.push_back(beat);
    end
    for (int k = count - 1; k >= 0; k--) begin
      beat.character = CHAR_ZERO + CHAR_W'(digits[k]);
      beat.last      = (k == 0);
      expected_text.push_back(beat);
    end
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    logic [63:0] power;
    int          pick;
    pick = $urandom_range(9);
    v    = {$urandom, $urandom};
    case (pick) inside
      [0:2]: begin
      end
      [3:6]: begin
        v = v & ({64{1'b1}} >> $urandom_range(63));
        if ($urandom_range(1) == 1) v = 64'd0 - v;
      end
      7: begin
        power = 64'd1;
        repeat ($urandom_range(18)) power = power * 64'd10;
        v = power + 64'($urandom_range(2)) - 64'd1;
        if ($urandom_range(1) == 1) v = 64'd0 - v;
      end
      8: begin
        v = 64'($urandom_range(40)) - 64'd20;
      end
      default: begin
        case ($urandom_range(3))
          0:       v = 64'h8000_0000_0000_0000;
          1:       v = 64'h8000_0000_0000_0001;
          2:       v = 64'h7FFF_FFFF_FFFF_FFFF;
          default: v = 64'h7FFF_FFFF_FFFF_FFFE;
        endcase
      end
    endcase
    return v;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_decimal_text(value_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          value_i    <= pending_values.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver, with the long hold-off counted here
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    text_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected beat, actual character=%0d last=%0b",
                 $time, character_o, last_o);
        errors++;
      end else begin
        want = expected_text.pop_front();
        if (character_o !== want.character) begin
          $display("%0t: character mismatch, expected %0d actual %0d",
                   $time, want.character, character_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last mismatch, expected %0b actual %0b",
                   $time, want.last, last_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_until_drained();
    while (pending_values.size() != 0 || in_valid_i || expected_text.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic queue_random(input int n);
    repeat (n) pending_values.push_back(random_value());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 25;
    recv_idle_pct = 72;
    pending_values.push_back(64'd0);
    pending_values.push_back(64'd1);
    pending_values.push_back(64'd0 - 64'd1);
    pending_values.push_back(64'd9);
    pending_values.push_back(64'd10);
    pending_values.push_back(64'd0 - 64'd10);
    pending_values.push_back(64'd99);
    pending_values.push_back(64'd100);
    pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    pending_values.push_back(64'h8000_0000_0000_0000);
    pending_values.push_back(64'h8000_0000_0000_0001);
    pending_values.push_back(64'd999_999_999_999_999_999);
    pending_values.push_back(64'd0 - 64'd999_999_999_999_999_999);
    pending_values.push_back(64'd1_000_000_000_000_000_000);
    pending_values.push_back(64'd0 - 64'd1_000_000_000_000_000_000);
    pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_values.push_back(64'h5555_5555_5555_5555);
    pending_values.push_back(64'd12_345_678_901_234_567);
    pending_values.push_back(64'd4_294_967_296);
    pending_values.push_back(64'd0 - 64'd5);
    wait_until_drained();

    queue_random(RANDOM_ITEMS_PER_PHASE);
    wait_until_drained();

    send_idle_pct = 72;
    recv_idle_pct = 25;
    queue_random(RANDOM_ITEMS_PER_PHASE);
    wait_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    queue_random(RANDOM_ITEMS_PER_PHASE);
    wait_until_drained();

    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (errors == 0 && expected_text.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
src/sbda_pkg.sv
src/signed_binary_to_decimal_ascii_unit.sv
dv/tb_signed_binary_to_decimal_ascii_unit.sv
